// ===== sv/crl_pkg.sv =====
// Shared types and constants for the colour ramp lookup block.
package crl_pkg;

   // Request kinds carried on req_type.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // Fixed field widths of the transaction payload.
   localparam int ReqPosW  = 10;
   localparam int ChanW    = 8;

   // The interpolated channel always lies between its two key values, so
   // eight quotient bits are enough.
   localparam int QuoBits  = 8;
   localparam int QuoCntW  = 3;

   localparam logic [ChanW-1:0] AlphaOn = 8'd255;

   // Colours of the two keys present after reset.
   localparam logic [ChanW-1:0] DefRed0   = 8'd255;
   localparam logic [ChanW-1:0] DefGreen0 = 8'd0;
   localparam logic [ChanW-1:0] DefBlue0  = 8'd0;
   localparam logic [ChanW-1:0] DefRed1   = 8'd127;
   localparam logic [ChanW-1:0] DefGreen1 = 8'd255;
   localparam logic [ChanW-1:0] DefBlue1  = 8'd255;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_DUP         = 2'd1,
      STAT_FULL        = 2'd2,
      STAT_NOT_COVERED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT0,
      S_INIT1,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_PLACE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_WR,
      S_MUL,
      S_DIV,
      S_RESP
   } state_type;

endpackage

// ===== sv/color_ramp_lut.sv =====
// Colour ramp lookup: sorted key table in a memory, linear interpolation by divider.
// Read: each key visited takes a registered memory read, then a compare; a multiply,
// a bit-serial divide and a response state follow.
// Insert: keys are visited likewise, then each key above the slot moves up (read, then
// write), at most MAX_KEYS keys in all; then the new key is written.
// One transaction at a time. Reset writes the two default keys; none is accepted before.
module color_ramp_lut
   import crl_pkg::*;
#(
   parameter int LUT_ENTRIES = 1024,
   parameter int MAX_KEYS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [ReqPosW-1:0]  req_position,
   input  logic [ChanW-1:0]    req_key_red,
   input  logic [ChanW-1:0]    req_key_green,
   input  logic [ChanW-1:0]    req_key_blue,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [ChanW-1:0]    rsp_out_red,
   output logic [ChanW-1:0]    rsp_out_green,
   output logic [ChanW-1:0]    rsp_out_blue,
   output logic [ChanW-1:0]    rsp_out_alpha
);

   localparam int PosW = ($clog2(LUT_ENTRIES) > ReqPosW) ? $clog2(LUT_ENTRIES) : ReqPosW;
   localparam int KW   = $clog2(MAX_KEYS);
   localparam int CW   = $clog2(MAX_KEYS + 1);
   localparam int NumW = PosW + ChanW + 1;
   localparam int DivW = PosW + QuoBits;
   localparam logic [PosW-1:0] LastPos = PosW'(LUT_ENTRIES - 1);

   typedef struct packed {
      logic [PosW-1:0]  pos;
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } key_type;

   // Key memory, one read and one write port.
   key_type key_mem [MAX_KEYS];
   key_type rd_data_ff;
   logic          mem_we;
   logic [KW-1:0] mem_waddr;
   logic [KW-1:0] mem_raddr;
   key_type       mem_wdata;

   state_type state_ff, state_in;

   logic             type_ff;
   logic [PosW-1:0]  pos_ff;
   logic [ChanW-1:0] new_red_ff, new_green_ff, new_blue_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    idx_ff;
   logic [CW-1:0]    at_ff;
   key_type          lo_ff, hi_ff;
   logic [NumW-1:0]  num_ff [3];
   logic [QuoBits-1:0] quo_ff [3];
   logic [DivW-1:0]  div_ff;
   logic [QuoCntW-1:0] bit_ff;
   status_type       status_ff;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [ChanW-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;

   logic            req_accept;
   logic            rsp_load;
   logic            pos_out_range;
   logic [CW-1:0]   idx_next;
   logic            scan_last;
   logic            cur_eq, cur_gt;
   logic [PosW-1:0] d_hi, d_lo;
   logic [ChanW-1:0] s_chan [3];
   logic [ChanW-1:0] e_chan [3];
   logic            num_ge [3];

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem[mem_raddr];
   end

   // Conditions used by the sequencer.
   assign pos_out_range = (32'(req_position) >= 32'(LUT_ENTRIES));
   assign idx_next      = idx_ff + CW'(1);
   assign scan_last     = (idx_next == count_ff);
   assign cur_eq        = (rd_data_ff.pos == pos_ff);
   assign cur_gt        = (rd_data_ff.pos > pos_ff);
   assign d_hi          = hi_ff.pos - pos_ff;
   assign d_lo          = pos_ff - lo_ff.pos;

   assign s_chan[0] = lo_ff.red;
   assign s_chan[1] = lo_ff.green;
   assign s_chan[2] = lo_ff.blue;
   assign e_chan[0] = hi_ff.red;
   assign e_chan[1] = hi_ff.green;
   assign e_chan[2] = hi_ff.blue;

   // One restoring step per channel against the shared shifted divisor.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_ge[c] = (num_ff[c] >= NumW'(div_ff));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT0: state_in = S_INIT1;
         S_INIT1: state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (pos_out_range) begin
                  state_in = S_RESP;
               end else if (req_type == REQ_READ && count_ff < CW'(2)) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (type_ff == REQ_INSERT) begin
               if (cur_eq) begin
                  state_in = S_RESP;
               end else if (cur_gt || scan_last) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (idx_ff == '0 && cur_gt) begin
                  state_in = S_RESP;
               end else if (idx_ff != '0 && (cur_gt || cur_eq)) begin
                  state_in = S_MUL;
               end else if (scan_last) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_PLACE: begin
            if (32'(count_ff) >= 32'(MAX_KEYS)) begin
               state_in = S_RESP;
            end else if (at_ff == count_ff) begin
               state_in = S_INS_WR;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (idx_ff == at_ff) begin
               state_in = S_INS_WR;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_INS_WR: state_in = S_RESP;
         S_MUL:    state_in = S_DIV;
         S_DIV: begin
            if (bit_ff == QuoCntW'(QuoBits - 1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and memory port controls.
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = idx_ff[KW-1:0];
      mem_raddr = idx_ff[KW-1:0];
      mem_wdata = rd_data_ff;
      case (state_ff)
         S_INIT0: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{pos: '0, red: DefRed0, green: DefGreen0, blue: DefBlue0};
         end
         S_INIT1: begin
            mem_we    = 1'b1;
            mem_waddr = KW'(1);
            mem_wdata = '{pos: LastPos, red: DefRed1, green: DefGreen1, blue: DefBlue1};
         end
         S_IDLE: req_stall = 1'b0;
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_next[KW-1:0];
            mem_wdata = rd_data_ff;
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = at_ff[KW-1:0];
            mem_wdata = '{pos: pos_ff, red: new_red_ff, green: new_green_ff,
                          blue: new_blue_ff};
         end
         S_RESP: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Key count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(2);
      end else if (state_ff == S_INS_WR) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // Working registers of the current transaction.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               type_ff      <= req_type;
               pos_ff       <= PosW'(req_position);
               new_red_ff   <= req_key_red;
               new_green_ff <= req_key_green;
               new_blue_ff  <= req_key_blue;
               idx_ff       <= '0;
               status_ff    <= STAT_NOT_COVERED;
            end
         end
         S_SCAN_CHK: begin
            lo_ff     <= hi_ff;
            hi_ff     <= rd_data_ff;
            idx_ff    <= idx_next;
            at_ff     <= cur_gt ? idx_ff : idx_next;
            status_ff <= (type_ff == REQ_READ) ? STAT_NOT_COVERED : STAT_DUP;
         end
         S_PLACE: begin
            status_ff <= STAT_FULL;
            idx_ff    <= count_ff - CW'(1);
         end
         S_SHIFT_WR: begin
            idx_ff <= idx_ff - CW'(1);
         end
         S_INS_WR: begin
            status_ff <= STAT_OK;
         end
         S_MUL: begin
            for (int c = 0; c < 3; c++) begin
               num_ff[c] <= NumW'(s_chan[c]) * NumW'(d_hi) + NumW'(e_chan[c]) * NumW'(d_lo);
               quo_ff[c] <= '0;
            end
            div_ff <= DivW'(hi_ff.pos - lo_ff.pos) << (QuoBits - 1);
            bit_ff <= '0;
         end
         S_DIV: begin
            for (int c = 0; c < 3; c++) begin
               if (num_ge[c]) begin
                  num_ff[c] <= num_ff[c] - NumW'(div_ff);
               end
               quo_ff[c] <= {quo_ff[c][QuoBits-2:0], num_ge[c]};
            end
            div_ff    <= div_ff >> 1;
            bit_ff    <= bit_ff + QuoCntW'(1);
            status_ff <= STAT_OK;
         end
         default: ;
      endcase
   end

   // Result register: holds a finished transaction until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         if (type_ff == REQ_READ && status_ff == STAT_OK) begin
            rsp_red_ff   <= quo_ff[0];
            rsp_green_ff <= quo_ff[1];
            rsp_blue_ff  <= quo_ff[2];
            rsp_alpha_ff <= AlphaOn;
         end else begin
            rsp_red_ff   <= '0;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
            rsp_alpha_ff <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;

endmodule
